// ===== design/device_id_registry_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// device_id_registry_table_core macros
// Assertion helpers shared by the registry table RTL.
// ----------------------------------------------------------------------------
`ifndef DEVICE_ID_REGISTRY_TABLE_CORE_MACROS_SVH
`define DEVICE_ID_REGISTRY_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define DIDRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("didrt assertion failed");
// expression must never be true out of reset
`define DIDRT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `DIDRT_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define DIDRT_ASSERT(lbl, clk, rst_n, prop)
`define DIDRT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== design/didrt_pkg.sv =====
// ----------------------------------------------------------------------------
// didrt_pkg
// Widths, operation and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package didrt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  typedef struct packed {
    logic load;  // latch a new request and its match vector
    logic scan;  // walk the match vector one slot
    logic exec;  // apply the operation and latch the response
  } didrt_cmd_t;

  typedef struct packed {
    logic hit;   // match at current scan slot
    logic last;  // scan slot is the final one
    logic full;  // table holds CAPACITY ids
  } didrt_sts_t;

endpackage

// ===== design/didrt_req_if.sv =====
// ----------------------------------------------------------------------------
// didrt_req_if
// Request channel: operation kind and device id.
// ----------------------------------------------------------------------------
interface didrt_req_if import didrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   device_id;

  modport source (output valid, kind, device_id, input ready);
  modport sink   (input valid, kind, device_id, output ready);
endinterface

// ===== design/didrt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// didrt_rsp_if
// Response channel: status, position and entry count.
// ----------------------------------------------------------------------------
interface didrt_rsp_if import didrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, position, entry_count, input ready);
  modport sink   (input valid, status, position, entry_count, output ready);
endinterface

// ===== design/didrt_datapath.sv =====
// ----------------------------------------------------------------------------
// didrt_datapath
// Id table cells, match vector, scan index, count and response registers.
// ----------------------------------------------------------------------------
module didrt_datapath import didrt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  didrt_cmd_t          cmd_i,
  output didrt_sts_t          sts_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [ID_W-1:0]     device_id_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    position_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [ID_W-1:0]     table_q [CAPACITY];
  logic [ID_W-1:0]     table_d [CAPACITY];
  logic [ID_W-1:0]     nxt     [CAPACITY];
  logic [CW-1:0]       count_q, count_d;
  logic [ID_W-1:0]     id_q;
  logic [KIND_W-1:0]   kind_q;
  logic [CAPACITY-1:0] match_q, match_d;
  logic [IW-1:0]       idx_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [COUNT_W-1:0]  cnt_q;
  logic [31:0]         idx_ext, cnt_ext, count_ext;
  logic                hit, last, full;

  // neighbor taps for the compacting shift
  for (genvar g = 0; g < CAPACITY; g++) begin : g_nxt
    if (g + 1 < CAPACITY) begin : g_mid
      assign nxt[g] = table_q[g+1];
    end else begin : g_end
      assign nxt[g] = '0;
    end
  end

  assign hit       = match_q[idx_q];
  assign last      = (32'(idx_q) == CAPACITY - 1);
  assign full      = (32'(count_q) == CAPACITY);
  assign idx_ext   = 32'(idx_q);
  assign count_ext = 32'(count_q);
  assign cnt_ext   = 32'(count_d);

  assign sts_o.hit  = hit;
  assign sts_o.last = last;
  assign sts_o.full = full;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (table_q[i] == device_id_i) && (i < count_ext);
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = STATUS_OK;
    pos_d    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      table_d[i] = table_q[i];
    end
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_INSERT: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (i == count_ext) table_d[i] = id_q;
            end
            pos_d   = count_ext[POS_W-1:0];
            count_d = count_q + CW'(1);
          end
        end
        KIND_FIND: begin
          if (hit) begin
            pos_d = idx_ext[POS_W-1:0];
          end else begin
            status_d = STATUS_MISS;
          end
        end
        KIND_DELETE: begin
          if (hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (i >= idx_ext) table_d[i] = nxt[i];
              if (i + 1 == count_ext) table_d[i] = '0;
            end
            pos_d   = idx_ext[POS_W-1:0];
            count_d = count_q - CW'(1);
          end else begin
            status_d = STATUS_MISS;
          end
        end
        default: begin
          status_d = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        table_q[i] <= '0;
      end
    end else begin
      count_q <= count_d;
      for (int i = 0; i < CAPACITY; i++) begin
        table_q[i] <= table_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q    <= device_id_i;
      kind_q  <= kind_i;
      match_q <= match_d;
      idx_q   <= '0;
    end else if (cmd_i.scan && !hit && !last) begin
      idx_q <= idx_q + IW'(1);
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_count_o = cnt_q;

endmodule

// ===== design/didrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// didrt_ctrl
// Sequencer: accept, scan the match vector (find and delete only), execute, hold the response.
// ----------------------------------------------------------------------------
module didrt_ctrl import didrt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [KIND_W-1:0] req_kind_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output didrt_cmd_t        cmd_o,
  input  didrt_sts_t        sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   valid_q;

  assign cmd_o.load  = req_valid_i && ready_q;
  assign cmd_o.scan  = (state_q == S_SCAN);
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign req_ready_o = ready_q;
  assign rsp_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i && ready_q) begin
            ready_q <= 1'b0;
            if (req_kind_i == KIND_FIND || req_kind_i == KIND_DELETE) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_SCAN: begin
          if (sts_i.hit || sts_i.last) state_q <= S_EXEC;
        end
        S_EXEC: begin
          valid_q <= 1'b1;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready_i) begin
            valid_q <= 1'b0;
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/device_id_registry_table_core.sv =====
// ----------------------------------------------------------------------------
// device_id_registry_table_core
// Compacting id table with insert, find and delete of 8-bit device ids.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beat when
//  req_i    in   kind, device_id                  valid && ready
//  rsp_o    out  status, position, entry_count    valid && ready
//
// One request at a time. Insert and unused kinds go straight from the request
// beat to the execute step, after which response valid rises; find and delete
// first scan one slot at a time up to the first match (or CAPACITY - 1 on a miss).
// The next request beat can come only after the response has been taken.
// Reset clears the table and the count at once; no clearing pass.
// A stalled response holds and req_i stays not ready until it is taken.
// ----------------------------------------------------------------------------
`include "device_id_registry_table_core_macros.svh"

module device_id_registry_table_core import didrt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  didrt_req_if.sink    req_i,
  didrt_rsp_if.source  rsp_o
);

  didrt_cmd_t cmd;
  didrt_sts_t sts;

  didrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  didrt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (req_i.kind),
    .device_id_i   (req_i.device_id),
    .status_o      (rsp_o.status),
    .position_o    (rsp_o.position),
    .entry_count_o (rsp_o.entry_count)
  );

  // response only ever follows an execute step
  `DIDRT_ASSERT(a_rsp_after_exec, clk_i, rst_ni, $rose(rsp_o.valid) |-> $past(cmd.exec))
  // never take a request while a response is pending
  `DIDRT_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, req_i.ready && rsp_o.valid)
  // a full refusal means the table really is full
  `DIDRT_ASSERT(a_full_status, clk_i, rst_ni, (rsp_o.valid && rsp_o.status == STATUS_FULL) |-> sts.full)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the device id table against a cycle-free model of its list. A queue
// of operations feeds the request driver. Each accepted beat updates the model
// table, and the model's reply is queued and compared with the next response.
// ----------------------------------------------------------------------------
module testbench;
  import didrt_pkg::*;

  localparam int unsigned TABLE_DEPTH = CAPACITY_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam real CLK_PERIOD = 12.0;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned CHUNK_ITEMS = 150;   // three chunks, about 450 random ops
  localparam int unsigned BIAS_SPAN = 30;      // ops per fill or drain phase
  localparam int unsigned IDLE_PCT = 37;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned DRAIN_CYCLES = 40;   // covers the worst response, a scan to the last slot

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   device_id;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
  } table_reply_t;

  logic clk;
  logic rst_n;

  didrt_req_if req ();
  didrt_rsp_if rsp ();

  device_id_registry_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];

  logic [ID_W-1:0] model_ids [TABLE_DEPTH];
  int unsigned     model_count;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_asks = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left = 0;
  logic        steady = 1'b0;
  logic        req_took = 1'b0;

  int unsigned n_insert = 0;
  int unsigned n_find = 0;
  int unsigned n_delete = 0;
  int unsigned n_unused = 0;
  int unsigned n_full = 0;
  int unsigned n_miss = 0;

  // Model of the list: apply one op and return the reply it produces.
  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    int hit;
    r.status = STATUS_OK;
    r.position = '0;
    hit = -1;
    if (op.kind == KIND_FIND || op.kind == KIND_DELETE) begin
      for (int i = 0; i < model_count; i++) begin
        if (hit < 0 && model_ids[i] == op.device_id) hit = i;
      end
    end
    case (op.kind)
      KIND_INSERT: begin
        if (model_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          model_ids[model_count] = op.device_id;
          r.position = POS_W'(model_count);
          model_count++;
        end
      end
      KIND_FIND: begin
        if (hit < 0) r.status = STATUS_MISS;
        else r.position = POS_W'(hit);
      end
      KIND_DELETE: begin
        if (hit < 0) begin
          r.status = STATUS_MISS;
        end else begin
          r.position = POS_W'(hit);
          for (int i = hit; i + 1 < model_count; i++) model_ids[i] = model_ids[i + 1];
          model_ids[model_count - 1] = '0;
          model_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(model_count);
    return r;
  endfunction

  // Random op; ids mostly from a 16-value pool so finds and deletes hit often.
  function automatic table_op_t random_table_op(bit fill_bias);
    table_op_t op;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) op.kind = KIND_UNUSED;
    else if (roll < (fill_bias ? 65 : 30)) op.kind = KIND_INSERT;
    else if (roll < (fill_bias ? 80 : 50)) op.kind = KIND_FIND;
    else op.kind = KIND_DELETE;
    if ($urandom_range(99) < 70)
      op.device_id = {($urandom_range(1) != 0) ? 5'h1F : 5'h00, 3'($urandom_range(7))};
    else
      op.device_id = ID_W'($urandom_range(255));
    return op;
  endfunction

  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
    table_op_t op;
    op.kind = kind;
    op.device_id = id;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random_chunk();
    for (int i = 0; i < CHUNK_ITEMS; i++)
      pending_ops.push_back(random_table_op(((i / BIAS_SPAN) % 2) == 0));
  endtask

  // Returns right after a rising edge once nothing is queued, offered or owed.
  task automatic wait_table_idle();
    do @(posedge clk);
    while (pending_ops.size() > 0 || req.valid || expected_replies.size() > 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.kind = KIND_INSERT;
    req.device_id = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) model_ids[i] = '0;
    model_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Request driver: a new beat goes out once the previous one was taken.
  always @(negedge clk) begin
    table_op_t nxt;
    logic offer;
    if (rst_n) begin
      if (!req.valid || req_took) begin
        offer = pending_ops.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT);
        if (offer) begin
          nxt = pending_ops.pop_front();
          req.kind <= nxt.kind;
          req.device_id <= nxt.device_id;
        end
        req.valid <= offer;
      end
      rsp.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    req_took <= req.valid && req.ready;
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk) begin
    if (stall_asks != stall_seen) begin
      hold_left <= HOLD_CYCLES;
      stall_seen <= stall_asks;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response check first, then the model takes the accepted request.
  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t got;
    table_op_t op;
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected response: status %0d position %0d entry_count %0d",
                 rsp.status, rsp.position, rsp.entry_count);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp.position);
            mismatches++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        op.kind = req.kind;
        op.device_id = req.device_id;
        got = apply_table_op(op);
        case (op.kind)
          KIND_INSERT: n_insert++;
          KIND_FIND:   n_find++;
          KIND_DELETE: n_delete++;
          default:     n_unused++;
        endcase
        if (got.status == STATUS_FULL) n_full++;
        if (got.status == STATUS_MISS) n_miss++;
        expected_replies.push_back(got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_replies.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // empty table: lookups miss, unused kind is a no-op
    queue_op(KIND_FIND, 8'h00);
    queue_op(KIND_DELETE, 8'h00);
    queue_op(KIND_UNUSED, 8'h5A);
    // fill to capacity, with a duplicate and walking bits
    queue_op(KIND_INSERT, 8'h00);
    queue_op(KIND_INSERT, 8'hFF);
    for (int b = 0; b < ID_W; b++) queue_op(KIND_INSERT, ID_W'(1 << b));
    queue_op(KIND_INSERT, 8'hFF);
    queue_op(KIND_INSERT, 8'h55);
    queue_op(KIND_INSERT, 8'hAA);
    queue_op(KIND_INSERT, 8'h0F);
    queue_op(KIND_INSERT, 8'h3C);
    queue_op(KIND_INSERT, 8'h33);
    queue_op(KIND_INSERT, 8'h77);    // refused, table full
    queue_op(KIND_UNUSED, 8'hA5);
    queue_op(KIND_FIND, 8'hFF);      // first of two copies
    queue_op(KIND_FIND, 8'h33);      // last slot
    queue_op(KIND_DELETE, 8'h00);    // head, shifts everything down
    queue_op(KIND_DELETE, 8'h33);    // now the tail
    queue_op(KIND_FIND, 8'h77);
    queue_op(KIND_DELETE, 8'h99);
    wait_table_idle();

    queue_random_chunk();
    wait_table_idle();

    // sender keeps offering while the receiver holds off
    queue_random_chunk();
    @(negedge clk);
    stall_asks++;
    wait_table_idle();

    steady = 1'b1;
    queue_random_chunk();
    wait_table_idle();
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ops: %0d insert (%0d refused full), %0d find, %0d delete, %0d unused kind",
             n_insert, n_full, n_find, n_delete, n_unused);
    $display("%0d lookups missed, %0d mismatches, %0d cycles", n_miss, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
